[sv/tcw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// shared geometry, codes and control structs of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS   = 80;
  localparam int LINES     = 25;
  localparam int TAB_WIDTH = 8;

  localparam int CELL_COUNT = COLUMNS * LINES;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS + 1);
  localparam int ROW_W      = $clog2(LINES + 1);
  localparam int PH_W       = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam int STOP_W     = $clog2(COLUMNS + TAB_WIDTH + 1);
  localparam int LIN_W      = $clog2(CELL_COUNT + COLUMNS);
  localparam int CELL_W     = 16;
  localparam int CELL_IDX_W = 11;

  // scroll walk: copy region, then one cleared row
  localparam int COPY_COUNT   = COLUMNS * (LINES - 2);
  localparam int SCROLL_COUNT = COLUMNS * (LINES - 1);

  // request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // special characters
  localparam logic [7:0] CHAR_NUL = 8'd0;
  localparam logic [7:0] CHAR_TAB = 8'd9;
  localparam logic [7:0] CHAR_NL  = 8'd10;

  // command from the sequencer to the cursor unit
  typedef struct packed {
    logic step;     // process one character
    logic dec_row;  // scroll just happened: move the line up first
    logic first;    // first character of a string
    logic home;     // clear screen: cursor to the origin
  } tcw_cur_cmd_t;

  // status from the cursor unit
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_next;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
  } tcw_cur_stat_t;

endpackage
`default_nettype wire

[sv/text_console_writer_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_core
// text-mode console: cell store, cursor, tabs, wrap, scroll, clear and read
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result beat
// appears on the result ports for exactly one cycle with done high, and the
// receiver has no way to stall it, so it must sample every done cycle.
// A printed character, newline, tab, read or unused request updates the
// cursor and writes or reads the store in S_EXEC, then gives its result beat,
// during which a new request may already be accepted. A first-of-string
// character at the bottom line also scrolls: the store has a single write
// port, so the scroll walk moves the rows up through S_SCROLL and S_DRAIN
// before the character is processed in S_STEP. A clear request walks the
// whole store one cell per cycle before its result beat. After reset the
// block runs a clearing pass over the whole store with busy high before it
// takes its first request.
// ----------------------------------------------------------------------------
module text_console_writer_core
  import tcw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request side
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            req_type,
  input  wire logic [7:0]            char_code,
  input  wire logic [7:0]            attribute,
  input  wire logic                  first_of_string,
  input  wire logic [CELL_IDX_W-1:0] cell_index,
  // result side
  output logic                       done,
  output logic [7:0]                 read_char,
  output logic [7:0]                 read_attr,
  output logic [6:0]                 cursor_column,
  output logic [4:0]                 cursor_line,
  output logic                       char_written
);

  localparam int CMP_W = (ADDR_W > CELL_IDX_W) ? ADDR_W : CELL_IDX_W;
  localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] LAST_SCROLL = ADDR_W'(SCROLL_COUNT - 1);

  typedef enum logic [2:0] {
    S_INIT,    // clearing pass after reset
    S_IDLE,
    S_EXEC,    // cursor update, store write, read data return
    S_SCROLL,  // move rows up, clear the row above the last
    S_DRAIN,   // last delayed scroll write
    S_STEP,    // character after a scroll
    S_CLEAR    // clear request walk
  } state_t;

  state_t state;

  // latched request
  logic [1:0]        lat_req;
  logic [7:0]        lat_char;
  logic [7:0]        lat_attr;
  logic              lat_first;
  logic              lat_in_range;

  // walk counter shared by init, clear and scroll
  logic [ADDR_W-1:0] sweep;

  // delayed scroll write: read at sweep+COLUMNS, write at sweep in the cycle after
  logic              pend;
  logic              pend_zero;
  logic [ADDR_W-1:0] pend_addr;

  // store ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // cursor unit
  tcw_cur_cmd_t      cmd;
  tcw_cur_stat_t     stat;

  logic [CMP_W-1:0]  idx_ext;
  logic              idx_in_range;
  logic              need_scroll;
  logic              copy_phase;

  assign idx_ext      = CMP_W'(cell_index);
  assign idx_in_range = (idx_ext < CMP_W'(CELL_COUNT));
  assign need_scroll  = lat_first && (stat.row >= ROW_W'(LINES - 1));
  assign copy_phase   = (sweep < ADDR_W'(COPY_COUNT));

  assign busy = (state != S_IDLE);

  // cursor commands
  always_comb begin
    cmd = '0;
    cmd.first = lat_first;
    unique case (state)
      S_EXEC: begin
        cmd.step = (lat_req == REQ_WRITE) && !need_scroll;
        cmd.home = (lat_req == REQ_CLEAR);
      end
      S_STEP: begin
        cmd.step    = 1'b1;
        cmd.dec_row = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // read port: requests in idle, source rows during the scroll
  always_comb begin
    if (state == S_IDLE) begin
      ram_re    = start && (req_type == REQ_READ) && idx_in_range;
      ram_raddr = ADDR_W'(idx_ext);
    end else begin
      ram_re    = (state == S_SCROLL) && copy_phase;
      ram_raddr = sweep + ADDR_W'(COLUMNS);
    end
  end

  // write port: walks first, then delayed scroll writes, then characters
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep;
    ram_wdata = '0;
    priority if (state == S_INIT || state == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (pend) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr;
      ram_wdata = pend_zero ? '0 : ram_rdata;
    end else if (stat.wr_en) begin
      ram_we    = 1'b1;
      ram_waddr = stat.wr_addr;
      ram_wdata = {lat_attr, lat_char};
    end
  end

  tcw_cell_store u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_cursor_unit u_cursor (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .char_code (lat_char),
    .stat      (stat)
  );

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      sweep <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      unique case (state)
        S_INIT: begin
          done <= 1'b0;
          if (sweep == LAST_CELL) begin
            sweep <= '0;
            state <= S_IDLE;
          end else begin
            sweep <= sweep + ADDR_W'(1);
          end
        end

        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            lat_req      <= req_type;
            lat_char     <= char_code;
            lat_attr     <= attribute;
            lat_first    <= first_of_string;
            lat_in_range <= idx_in_range;
            state        <= S_EXEC;
          end
        end

        S_EXEC: begin
          if (lat_req == REQ_WRITE && need_scroll) begin
            done  <= 1'b0;
            sweep <= '0;
            state <= S_SCROLL;
          end else if (lat_req == REQ_CLEAR) begin
            done  <= 1'b0;
            sweep <= '0;
            state <= S_CLEAR;
          end else begin
            // write, read or unused code: result beat now
            done          <= 1'b1;
            char_written  <= stat.wr_en;
            cursor_column <= 7'(stat.col_next);
            cursor_line   <= 5'(stat.row_next);
            if (lat_req == REQ_READ && lat_in_range) begin
              read_char <= ram_rdata[7:0];
              read_attr <= ram_rdata[15:8];
            end else begin
              read_char <= '0;
              read_attr <= '0;
            end
            state <= S_IDLE;
          end
        end

        S_SCROLL: begin
          done      <= 1'b0;
          pend      <= 1'b1;
          pend_addr <= sweep;
          pend_zero <= !copy_phase;
          sweep     <= sweep + ADDR_W'(1);
          if (sweep == LAST_SCROLL) begin
            state <= S_DRAIN;
          end
        end

        S_DRAIN: begin
          done  <= 1'b0;
          pend  <= 1'b0;
          sweep <= '0;
          state <= S_STEP;
        end

        S_STEP: begin
          done          <= 1'b1;
          char_written  <= stat.wr_en;
          cursor_column <= 7'(stat.col_next);
          cursor_line   <= 5'(stat.row_next);
          read_char     <= '0;
          read_attr     <= '0;
          state         <= S_IDLE;
        end

        S_CLEAR: begin
          if (sweep == LAST_CELL) begin
            sweep         <= '0;
            done          <= 1'b1;
            char_written  <= 1'b0;
            cursor_column <= 7'(stat.col_next);
            cursor_line   <= 5'(stat.row_next);
            read_char     <= '0;
            read_attr     <= '0;
            state         <= S_IDLE;
          end else begin
            done  <= 1'b0;
            sweep <= sweep + ADDR_W'(1);
          end
        end

        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result beat only when the sequencer has returned to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  // an accepted request holds off the next one
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  // a stored character always comes with its result beat
  a_written_done: assert property (@(posedge clk) disable iff (rst)
    stat.wr_en |=> done)
    else $error("character stored without a result beat");

  // scroll reads stay ahead of the delayed writes
  a_scroll_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCROLL && ram_re) |-> (ram_raddr > ram_waddr))
    else $error("scroll read behind its write");

  // cursor column never rests at or past the row end
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    stat.col_next < COL_W'(COLUMNS))
    else $error("cursor column out of range");

endmodule
`default_nettype wire

[sv/tcw_cell_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_cell_store
// character and attribute store, one write port, one registered read port
// ----------------------------------------------------------------------------
module tcw_cell_store
  import tcw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [CELL_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[sv/tcw_cursor_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_cursor_unit
// cursor column, line, tab phase and string length, with the character rules
// ----------------------------------------------------------------------------
module tcw_cursor_unit
  import tcw_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tcw_cur_cmd_t  cmd,
  input  wire logic [7:0]    char_code,
  output tcw_cur_stat_t      stat
);

  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [PH_W-1:0]   phase;   // column modulo tab width
  logic [COL_W-1:0]  cnt;     // characters consumed of this string

  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row_next;
  logic [PH_W-1:0]   phase_next;
  logic [COL_W-1:0]  cnt_next;

  logic [ROW_W-1:0]  row_eff;
  logic [ROW_W-1:0]  row_down;
  logic [COL_W-1:0]  cnt_eff;
  logic [COL_W-1:0]  col_inc;
  logic [STOP_W-1:0] stop;
  logic [LIN_W-1:0]  lin;
  logic              wr_en;

  always_comb begin
    row_eff  = cmd.dec_row ? row - ROW_W'(1) : row;
    cnt_eff  = cmd.first ? '0 : cnt;
    row_down = (row_eff < ROW_W'(LINES)) ? row_eff + ROW_W'(1) : row_eff;
    col_inc  = col + COL_W'(1);
    stop     = STOP_W'(col) - STOP_W'(phase) + STOP_W'(TAB_WIDTH);
    lin      = LIN_W'(row_eff) * LIN_W'(COLUMNS) + LIN_W'(col);

    col_next   = col;
    row_next   = row;
    phase_next = phase;
    cnt_next   = cnt;
    wr_en      = 1'b0;

    if (cmd.home) begin
      col_next   = '0;
      row_next   = '0;
      phase_next = '0;
    end else if (cmd.step) begin
      row_next = row_eff;
      cnt_next = cnt_eff;
      if (cnt_eff < COL_W'(COLUMNS)) begin
        if (char_code == CHAR_NUL) begin
          // end of string: ignore the rest
          cnt_next = COL_W'(COLUMNS);
        end else begin
          cnt_next = cnt_eff + COL_W'(1);
          if (char_code == CHAR_NL) begin
            col_next   = '0;
            phase_next = '0;
            row_next   = row_down;
          end else if (char_code == CHAR_TAB) begin
            phase_next = '0;
            if (stop >= STOP_W'(COLUMNS)) begin
              col_next = '0;
              row_next = row_down;
            end else begin
              col_next = COL_W'(stop);
            end
          end else begin
            wr_en = (row_eff < ROW_W'(LINES));
            if (col_inc >= COL_W'(COLUMNS)) begin
              col_next   = '0;
              phase_next = '0;
              row_next   = row_down;
            end else begin
              col_next   = col_inc;
              phase_next = (phase == PH_W'(TAB_WIDTH - 1)) ? '0 : phase + PH_W'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      phase <= '0;
      cnt   <= '0;
    end else begin
      col   <= col_next;
      row   <= row_next;
      phase <= phase_next;
      cnt   <= cnt_next;
    end
  end

  assign stat.row      = row;
  assign stat.col_next = col_next;
  assign stat.row_next = row_next;
  assign stat.wr_en    = wr_en;
  assign stat.wr_addr  = ADDR_W'(lin);

endmodule
`default_nettype wire
